### hw/rtl/xoshiro128pp_rng_with_bounded_draw_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the xoshiro128++ bounded draw core
// Concurrent checks that compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef XOSHIRO128PP_RNG_WITH_BOUNDED_DRAW_CORE_DEFINES_SVH
`define XOSHIRO128PP_RNG_WITH_BOUNDED_DRAW_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define XRB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("xrb assertion failed");
`define XRB_NEVER(lbl, clk, rstn, cond) \
  `XRB_ASSERT(lbl, clk, rstn, !(cond))
`else
`define XRB_ASSERT(lbl, clk, rstn, prop)
`define XRB_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### hw/rtl/xrb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xrb_pkg
// Types, codes and constants shared by the bounded draw core.
// ---------------------------------------------------------------------------
package xrb_pkg;

  localparam logic [1:0] FUNC_RESEED = 2'd0;
  localparam logic [1:0] FUNC_RAW    = 2'd1;
  localparam logic [1:0] FUNC_BIASED = 2'd2;
  localparam logic [1:0] FUNC_EXACT  = 2'd3;

  localparam logic CFG_SEED  = 1'b0;
  localparam logic CFG_JUMPS = 1'b1;

  localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

  localparam logic [3:0][31:0] JUMP_POLY = {32'h1c580662, 32'hccf5a0ef,
                                            32'h0b6f099f, 32'hb523952e};

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH_IN,
    CMD_LOAD_SEED,
    CMD_SM_ADD,
    CMD_SM_MUL,
    CMD_SM_MIX,
    CMD_SM_FIN,
    CMD_JSTEP,
    CMD_JCOMMIT,
    CMD_DRAW,
    CMD_BMUL,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_OUT_LOAD
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [1:0] ph;
    logic       pass;
    logic [1:0] widx;
    logic [6:0] jidx;
    logic       first;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       bound_zero;
    logic       low_lt_bound;
    logic       low_lt_thr;
    logic       zero_state;
    logic [7:0] jump_count;
  } dp_sts_t;

endpackage

### hw/rtl/xrb_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xrb_req_if / xrb_rsp_if
// Valid/ready channels for operation requests and draw results.
// ---------------------------------------------------------------------------
interface xrb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] bound;
  modport source (output valid, func, bound, input ready);
  modport sink   (input valid, func, bound, output ready);
endinterface

interface xrb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        bad_bound;
  modport source (output valid, value, bad_bound, input ready);
  modport sink   (input valid, value, bad_bound, output ready);
endinterface

### hw/rtl/xoshiro128pp_rng_with_bounded_draw_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xoshiro128pp_rng_with_bounded_draw_core
// xoshiro128++ generator with SplitMix64 reseed, long jumps and bounded draws.
// ---------------------------------------------------------------------------
// One request beat gives one result beat, one request at a time. A biased
// draw with bound zero takes no draw. An exact draw adds the remainder
// threshold (a 32-step restoring remainder unit) and a new draw per
// rejected draw when a retry is needed. Reseed builds the SplitMix64
// products from three 32x32 partial products on one shared multiplier,
// twice per output, then runs each configured long jump as one xoshiro step
// per polynomial bit. After reset the generator words are zero and every
// draw returns zero, so issue a reseed first. A finished result sits in an
// output register, so a new request is taken while the previous result
// waits. Config writes are for idle periods only.
module xoshiro128pp_rng_with_bounded_draw_core
  import xrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: index 0 seed_value, index 1 jump_count
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  xrb_req_if.sink     req_i,
  xrb_rsp_if.source   rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: state machine issuing datapath commands
  xrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: generator words, SplitMix counter, multiplier, remainder unit
  xrb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_func_i   (req_i.func),
    .in_bound_i  (req_i.bound),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_value_o (rsp_o.value),
    .out_bad_o   (rsp_o.bad_bound)
  );

endmodule

### hw/rtl/xrb_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xrb_dpath
// Generator state, shared 32x32 multiplier, remainder unit, output register.
// ---------------------------------------------------------------------------
module xrb_dpath
  import xrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  in_func_i,
  input  logic [31:0] in_bound_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic [31:0] out_value_o,
  output logic        out_bad_o
);

  logic [31:0] seed_q;
  logic [7:0]  jumps_q;
  logic [1:0]  func_q;
  logic [31:0] bound_q;
  logic [63:0] ctr_q, ctr_d;
  logic [63:0] z_q, z_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0][31:0] w_q, w_d;
  logic [3:0][31:0] jacc_q, jacc_d;
  logic [31:0] res_q, res_d;
  logic [63:0] m_q, m_d;
  logic        zero_q, zero_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] out_value_q, out_value_d;
  logic        out_bad_q, out_bad_d;

  // xoshiro128++ step
  logic [31:0] sum03, xo_res;
  logic [3:0][31:0] w_nx;
  logic [31:0] t2, t3;
  always_comb begin
    sum03   = w_q[0] + w_q[3];
    xo_res  = {sum03[24:0], sum03[31:25]} + w_q[0];
    t2      = w_q[2] ^ w_q[0];
    t3      = w_q[3] ^ w_q[1];
    w_nx[1] = w_q[1] ^ t2;
    w_nx[0] = w_q[0] ^ t3;
    w_nx[2] = t2 ^ {w_q[1][22:0], 9'd0};
    w_nx[3] = {t3[20:0], t3[31:21]};
  end

  // shared multiplier
  logic [63:0] mconst;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    mconst = cmd_i.pass ? SM_MUL2 : SM_MUL1;
    if (cmd_i.op == CMD_BMUL) begin
      mul_a = res_q;
      mul_b = bound_q;
    end else begin
      mul_a = (cmd_i.ph == 2'd2) ? z_q[63:32] : z_q[31:0];
      mul_b = (cmd_i.ph == 2'd1) ? mconst[63:32] : mconst[31:0];
    end
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  logic [63:0] ctr_add, fin_mix;
  logic [32:0] rsh;
  logic        pbit;
  always_comb begin
    ctr_add = ctr_q + SM_GAMMA;
    fin_mix = acc_q ^ (acc_q >> 31);
    rsh     = {rem_q, dvd_q[31]};
    pbit    = JUMP_POLY[cmd_i.jidx[6:5]][cmd_i.jidx[4:0]];
  end

  always_comb begin
    ctr_d       = ctr_q;
    z_d         = z_q;
    acc_d       = acc_q;
    w_d         = w_q;
    jacc_d      = jacc_q;
    res_d       = res_q;
    m_d         = m_q;
    zero_d      = zero_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    out_value_d = out_value_q;
    out_bad_d   = out_bad_q;
    case (cmd_i.op)
      CMD_LOAD_SEED: ctr_d = {{32{seed_q[31]}}, seed_q};
      CMD_SM_ADD: begin
        ctr_d = ctr_add;
        z_d   = ctr_add ^ (ctr_add >> 30);
      end
      CMD_SM_MUL: begin
        if (cmd_i.ph == 2'd0) acc_d = prod;
        else acc_d = acc_q + {prod[31:0], 32'd0};
      end
      CMD_SM_MIX: z_d = acc_q ^ (acc_q >> 27);
      CMD_SM_FIN: w_d[cmd_i.widx] = fin_mix[63:32];
      CMD_JSTEP: begin
        jacc_d = (cmd_i.jidx == 7'd0) ? '0 : jacc_q;
        if (pbit) begin
          jacc_d[0] = jacc_d[0] ^ w_q[0];
          jacc_d[1] = jacc_d[1] ^ w_q[1];
          jacc_d[2] = jacc_d[2] ^ w_q[2];
          jacc_d[3] = jacc_d[3] ^ w_q[3];
        end
        w_d = w_nx;
      end
      CMD_JCOMMIT: w_d = jacc_q;
      CMD_DRAW: begin
        if (cmd_i.first) zero_d = (w_q == '0);
        res_d = xo_res;
        w_d   = w_nx;
      end
      CMD_BMUL: m_d = prod;
      CMD_DIV_INIT: begin
        rem_d = '0;
        dvd_d = 32'd0 - bound_q;
      end
      CMD_DIV_STEP: begin
        dvd_d = {dvd_q[30:0], 1'b0};
        if (rsh >= {1'b0, bound_q}) rem_d = 32'(rsh - {1'b0, bound_q});
        else rem_d = rsh[31:0];
      end
      CMD_OUT_LOAD: begin
        out_bad_d = 1'b0;
        case (func_q)
          FUNC_RESEED: out_value_d = '0;
          FUNC_RAW:    out_value_d = res_q;
          FUNC_BIASED: begin
            out_value_d = (bound_q == '0) ? 32'd0 : m_q[63:32];
            out_bad_d   = (bound_q == '0);
          end
          default:     out_value_d = m_q[63:32];
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      jumps_q <= '0;
      ctr_q   <= '0;
      w_q     <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_SEED) seed_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_JUMPS) jumps_q <= cfg_data_i[7:0];
      ctr_q <= ctr_d;
      w_q   <= w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_LATCH_IN) begin
      func_q  <= in_func_i;
      bound_q <= in_bound_i;
    end
    z_q         <= z_d;
    acc_q       <= acc_d;
    jacc_q      <= jacc_d;
    res_q       <= res_d;
    m_q         <= m_d;
    zero_q      <= zero_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    out_value_q <= out_value_d;
    out_bad_q   <= out_bad_d;
  end

  assign sts_o.func         = func_q;
  assign sts_o.bound_zero   = (bound_q == '0);
  assign sts_o.low_lt_bound = (m_q[31:0] < bound_q);
  assign sts_o.low_lt_thr   = (m_q[31:0] < rem_q);
  assign sts_o.zero_state   = zero_q;
  assign sts_o.jump_count   = jumps_q;
  assign out_value_o        = out_value_q;
  assign out_bad_o          = out_bad_q;

endmodule

### hw/rtl/xrb_ctrl.sv
`timescale 1ns / 1ps
`include "xoshiro128pp_rng_with_bounded_draw_core_defines.svh"
// ---------------------------------------------------------------------------
// xrb_ctrl
// Sequencer for reseed, long jumps, draws and the rejection threshold.
// ---------------------------------------------------------------------------
module xrb_ctrl
  import xrb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SM_ADD, S_SM_MUL, S_SM_MIX, S_SM_FIN,
    S_JSTEP, S_JCOMMIT, S_DRAW, S_BMUL, S_CHECK, S_DIV, S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] wi_q, wi_d;
  logic [1:0] ph_q, ph_d;
  logic       pass_q, pass_d;
  logic [7:0] jleft_q, jleft_d;
  logic [6:0] jidx_q, jidx_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic       first_q, first_d;
  logic       out_valid_q, out_valid_d;
  dp_cmd_t    cmd;

  always_comb begin
    state_d = state_q;
    wi_d    = wi_q;
    ph_d    = ph_q;
    pass_d  = pass_q;
    jleft_d = jleft_q;
    jidx_d  = jidx_q;
    dcnt_d  = dcnt_q;
    first_d = first_q;
    cmd       = '0;
    cmd.op    = CMD_NONE;
    cmd.ph    = ph_q;
    cmd.pass  = pass_q;
    cmd.widx  = wi_q;
    cmd.jidx  = jidx_q;
    cmd.first = first_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd.op  = CMD_LATCH_IN;
        state_d = S_DEC;
      end
      S_DEC: begin
        first_d = 1'b1;
        unique case (sts_i.func)
          FUNC_RESEED: begin
            cmd.op  = CMD_LOAD_SEED;
            wi_d    = '0;
            state_d = S_SM_ADD;
          end
          FUNC_BIASED: state_d = sts_i.bound_zero ? S_FIN : S_DRAW;
          default:     state_d = S_DRAW;
        endcase
      end
      S_SM_ADD: begin
        cmd.op  = CMD_SM_ADD;
        ph_d    = '0;
        pass_d  = 1'b0;
        state_d = S_SM_MUL;
      end
      S_SM_MUL: begin
        cmd.op = CMD_SM_MUL;
        ph_d   = ph_q + 2'd1;
        if (ph_q == 2'd2) state_d = pass_q ? S_SM_FIN : S_SM_MIX;
      end
      S_SM_MIX: begin
        cmd.op  = CMD_SM_MIX;
        ph_d    = '0;
        pass_d  = 1'b1;
        state_d = S_SM_MUL;
      end
      S_SM_FIN: begin
        cmd.op = CMD_SM_FIN;
        wi_d   = wi_q + 2'd1;
        jidx_d = '0;
        if (wi_q != 2'd3) state_d = S_SM_ADD;
        else if (sts_i.jump_count == '0) state_d = S_FIN;
        else begin
          jleft_d = sts_i.jump_count;
          state_d = S_JSTEP;
        end
      end
      S_JSTEP: begin
        cmd.op = CMD_JSTEP;
        jidx_d = jidx_q + 7'd1;
        if (jidx_q == 7'd127) state_d = S_JCOMMIT;
      end
      S_JCOMMIT: begin
        cmd.op  = CMD_JCOMMIT;
        jleft_d = jleft_q - 8'd1;
        state_d = (jleft_q == 8'd1) ? S_FIN : S_JSTEP;
      end
      S_DRAW: begin
        cmd.op  = CMD_DRAW;
        state_d = (sts_i.func == FUNC_RAW) ? S_FIN : S_BMUL;
      end
      S_BMUL: begin
        cmd.op  = CMD_BMUL;
        state_d = (sts_i.func == FUNC_EXACT) ? S_CHECK : S_FIN;
      end
      S_CHECK: begin
        if (first_q) begin
          first_d = 1'b0;
          if (sts_i.low_lt_bound && !sts_i.zero_state) begin
            cmd.op  = CMD_DIV_INIT;
            dcnt_d  = '0;
            state_d = S_DIV;
          end else state_d = S_FIN;
        end else state_d = sts_i.low_lt_thr ? S_DRAW : S_FIN;
      end
      S_DIV: begin
        cmd.op = CMD_DIV_STEP;
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) state_d = S_CHECK;
      end
      S_FIN: if (!out_valid_q || out_ready_i) begin
        cmd.op  = CMD_OUT_LOAD;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.op == CMD_OUT_LOAD) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wi_q        <= '0;
      ph_q        <= '0;
      pass_q      <= 1'b0;
      jleft_q     <= '0;
      jidx_q      <= '0;
      dcnt_q      <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wi_q        <= wi_d;
      ph_q        <= ph_d;
      pass_q      <= pass_d;
      jleft_q     <= jleft_d;
      jidx_q      <= jidx_d;
      dcnt_q      <= dcnt_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `XRB_NEVER(a_no_overwrite, clk_i, rst_ni,
             cmd.op == CMD_OUT_LOAD && out_valid_q && !out_ready_i)
  `XRB_ASSERT(a_accept_decodes, clk_i, rst_ni,
              (in_valid_i && in_ready_o) |=> (state_q == S_DEC))
  `XRB_NEVER(a_div_nonzero, clk_i, rst_ni, state_q == S_DIV && sts_i.bound_zero)

endmodule

### test/xoshiro128pp_rng_with_bounded_draw_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xoshiro128pp_rng_with_bounded_draw_core_test
// Self-checking bench for the xoshiro128++ bounded draw core. An in-bench
// predictor tracks the SplitMix64 counter, the four generator words and both
// config registers. Every accepted request beat queues one expected result,
// and every accepted result beat is compared against the oldest one.
// Stimulus: directed corner cases, config sweeps, random traffic under
// several idle/stall mixes, and one long receiver hold-off.
// ---------------------------------------------------------------------------
module xoshiro128pp_rng_with_bounded_draw_core_test;
  import xrb_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        bad_bound;
  } draw_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_data;

  xrb_req_if req_if ();
  xrb_rsp_if rsp_if ();

  xoshiro128pp_rng_with_bounded_draw_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Predictor state: mirrors the block's architectural state.
  logic [63:0] mix_ctr;
  logic [31:0] gen_w [4];
  logic [31:0] seed_reg;
  logic [7:0]  jumps_reg;

  draw_res_t   expected_draws [$];
  bit          failed;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;

  // Clock, 8 ns period.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit: far beyond the slowest legal run (a 255-jump reseed
  // plus ~1200 draws under heavy stalls).
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int k);
    return (v << k) | (v >> (32 - k));
  endfunction

  // One xoshiro128++ step; returns the output word.
  function automatic logic [31:0] gen_step();
    logic [31:0] res;
    logic [31:0] sh;
    res = rotl32(gen_w[0] + gen_w[3], 7) + gen_w[0];
    sh  = gen_w[1] << 9;
    gen_w[2] ^= gen_w[0];
    gen_w[3] ^= gen_w[1];
    gen_w[1] ^= gen_w[2];
    gen_w[0] ^= gen_w[3];
    gen_w[2] ^= sh;
    gen_w[3] = rotl32(gen_w[3], 11);
    return res;
  endfunction

  function automatic logic [63:0] mix_next();
    logic [63:0] z;
    mix_ctr = mix_ctr + SM_GAMMA;
    z = mix_ctr;
    z = (z ^ (z >> 30)) * SM_MUL1;
    z = (z ^ (z >> 27)) * SM_MUL2;
    return z ^ (z >> 31);
  endfunction

  function automatic void apply_jump_poly();
    logic [31:0] acc [4];
    logic [31:0] unused;
    acc = '{default: '0};
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 32; b++) begin
        if (JUMP_POLY[w][b]) begin
          for (int j = 0; j < 4; j++) acc[j] ^= gen_w[j];
        end
        unused = gen_step();
      end
    end
    for (int j = 0; j < 4; j++) gen_w[j] = acc[j];
  endfunction

  function automatic void reseed_gen();
    logic [63:0] z;
    mix_ctr = {{32{seed_reg[31]}}, seed_reg};
    for (int i = 0; i < 4; i++) begin
      z = mix_next();
      gen_w[i] = z[63:32];
    end
    for (int i = 0; i < jumps_reg; i++) apply_jump_poly();
  endfunction

  function automatic draw_res_t predict_draw(input logic [1:0] fn,
                                             input logic [31:0] bnd);
    draw_res_t   r;
    logic [63:0] m;
    logic [31:0] thr;
    logic [31:0] neg_b;
    bit          zero_st;
    r = '0;
    case (fn)
      FUNC_RESEED: begin
        reseed_gen();
      end
      FUNC_RAW: begin
        r.value = gen_step();
      end
      FUNC_BIASED: begin
        if (bnd == '0) begin
          r.bad_bound = 1'b1;   // no draw, state holds
        end else begin
          m = {32'd0, gen_step()} * {32'd0, bnd};
          r.value = m[63:32];
        end
      end
      default: begin
        // Lemire: reject while low word under (2^32 - bound) mod bound.
        // All-zero state skips rejection so it can never spin.
        zero_st = (gen_w[0] | gen_w[1] | gen_w[2] | gen_w[3]) == '0;
        m = {32'd0, gen_step()} * {32'd0, bnd};
        if (m[31:0] < bnd && !zero_st) begin
          neg_b = -bnd;
          thr = neg_b % bnd;
          while (m[31:0] < thr) m = {32'd0, gen_step()} * {32'd0, bnd};
        end
        r.value = m[63:32];
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: ready driven at negedge, beats sampled at posedge.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    draw_res_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_draws.size() == 0) begin
        $display("%0t: unexpected result beat value=%h bad_bound=%b",
                 $time, rsp_if.value, rsp_if.bad_bound);
        failed = 1'b1;
      end else begin
        want = expected_draws.pop_front();
        if (rsp_if.value !== want.value) begin
          $display("%0t: value mismatch expected %h actual %h",
                   $time, want.value, rsp_if.value);
          failed = 1'b1;
        end
        if (rsp_if.bad_bound !== want.bad_bound) begin
          $display("%0t: bad_bound mismatch expected %b actual %b",
                   $time, want.bad_bound, rsp_if.bad_bound);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  // Offer one beat; returns after the accepting edge. valid stays high so
  // back-to-back beats need no gap.
  task automatic send_draw(input logic [1:0] fn, input logic [31:0] bnd);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      req_if.func  = 2'($urandom);
      req_if.bound = $urandom;
      @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.func  = fn;
    req_if.bound = bnd;
    do @(posedge clk_i); while (!req_if.ready);
    expected_draws.push_back(predict_draw(fn, bnd));
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (expected_draws.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Config writes only happen after drain(), i.e. with the core idle.
  task automatic write_cfg(input logic idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we   = 1'b0;
    if (idx == CFG_SEED) seed_reg = data;
    else jumps_reg = data[7:0];
  endtask

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'($urandom_range(1, 16));
      2: return 32'h1 << $urandom_range(31);
      3: return 32'h8000_0000 + 32'($urandom_range(1, 1000));   // heavy rejection
      4: return 32'hffff_ffff - 32'($urandom_range(3));
      5: return 32'($urandom_range(1, 100000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 3) return FUNC_RESEED;
    if (r < 40) return FUNC_RAW;
    if (r < 70) return FUNC_BIASED;
    return FUNC_EXACT;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Zero state after reset: every draw is zero; biased bound zero flags.
  task automatic test_unseeded();
    send_draw(FUNC_RAW, 32'd0);
    send_draw(FUNC_BIASED, 32'hffff_ffff);
    send_draw(FUNC_BIASED, 32'd0);
    send_draw(FUNC_EXACT, 32'd7);
    send_draw(FUNC_EXACT, 32'h8000_0001);
    send_draw(FUNC_EXACT, 32'd0);
    drain();
  endtask

  // Seed extremes, all ops and bound extremes, one long jump.
  task automatic test_directed();
    send_draw(FUNC_RESEED, 32'hffff_ffff);   // default seed 0
    send_draw(FUNC_RAW, 32'd0);
    drain();
    write_cfg(CFG_SEED, 32'h8000_0000);
    write_cfg(CFG_JUMPS, 32'd1);
    send_draw(FUNC_RESEED, 32'd0);
    send_draw(FUNC_BIASED, 32'd1);
    send_draw(FUNC_BIASED, 32'hffff_ffff);
    send_draw(FUNC_BIASED, 32'd0);
    send_draw(FUNC_EXACT, 32'd0);
    send_draw(FUNC_EXACT, 32'd1);
    send_draw(FUNC_EXACT, 32'hffff_ffff);
    send_draw(FUNC_EXACT, 32'h8000_0001);
    send_draw(FUNC_EXACT, 32'd3);
    drain();
    write_cfg(CFG_SEED, 32'h7fff_ffff);
    write_cfg(CFG_JUMPS, 32'd0);
    send_draw(FUNC_RESEED, 32'd0);
    send_draw(FUNC_RAW, 32'd0);
    send_draw(FUNC_EXACT, 32'h8000_0001);
    drain();
    write_cfg(CFG_SEED, 32'hffff_ffff);
    send_draw(FUNC_RESEED, 32'd0);
    send_draw(FUNC_RAW, 32'd0);
    drain();
  endtask

  // Max jump count, then a few random seed / jump settings.
  task automatic test_cfg_sweep();
    write_cfg(CFG_SEED, 32'h1234_5678);
    write_cfg(CFG_JUMPS, 32'd255);
    send_draw(FUNC_RESEED, 32'd0);
    send_draw(FUNC_RAW, 32'd0);
    send_draw(FUNC_EXACT, $urandom);
    drain();
    repeat (4) begin
      write_cfg(CFG_SEED, $urandom);
      write_cfg(CFG_JUMPS, 32'($urandom_range(3)));
      send_draw(FUNC_RESEED, 32'd0);
      repeat (5) send_draw(pick_func(), pick_bound());
      drain();
    end
  endtask

  // Random traffic with one idle mix; new seed/jumps at the phase start.
  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_cfg(CFG_SEED, $urandom);
    write_cfg(CFG_JUMPS, 32'($urandom_range(2)));
    send_draw(FUNC_RESEED, 32'd0);
    repeat (n) send_draw(pick_func(), pick_bound());
    drain();
  endtask

  // Receiver holds off while the sender keeps offering: the result
  // register fills and the request side must stall.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left = 400;
    repeat (30) send_draw(pick_func(), pick_bound());
    drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_SEED;
    cfg_data     = '0;
    req_if.valid = 1'b0;
    req_if.func  = FUNC_RAW;
    req_if.bound = '0;
    rsp_if.ready = 1'b0;
    failed       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left    = 0;
    mix_ctr      = '0;
    gen_w        = '{default: '0};
    seed_reg     = '0;
    jumps_reg    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_unseeded();
    test_directed();
    test_cfg_sweep();
    test_random(300, 0, 0);
    test_random(280, 56, 0);
    test_random(280, 0, 56);
    test_random(280, 36, 36);
    test_backpressure();

    repeat (20) @(posedge clk_i);
    if (!failed && expected_draws.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
